[sv/dpp_pkg.sv]
// Shared widths, register indexes and types for the dual-channel PID duty block.
`timescale 1ns / 1ps

package dpp_pkg;

  localparam int SAMPLE_BITS  = 10;
  localparam int TARGET_W     = SAMPLE_BITS;
  localparam int ERR_W        = SAMPLE_BITS + 1;
  localparam int DIFF_W       = ERR_W + 1;
  localparam int SUM_W        = 24;
  localparam int GAIN_W       = 20;
  localparam int FRAC_BITS    = 20;
  localparam int DRIVE_W      = 28;
  localparam int DUTY_W       = 8;
  localparam int OUTPUT_LIMIT = 128;
  localparam int WIDE_W       = 48;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = GAIN_W;

  localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
  localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [DRIVE_W-1:0] DRIVE_LIMIT = DRIVE_W'(OUTPUT_LIMIT << FRAC_BITS);

  localparam logic [GAIN_W-1:0] GAIN_P_RESET = GAIN_W'(73400);
  localparam logic [GAIN_W-1:0] GAIN_I_RESET = GAIN_W'(105);
  localparam logic [GAIN_W-1:0] GAIN_D_RESET = GAIN_W'(5243);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET_A = 3'd0,
    REG_TARGET_B = 3'd1,
    REG_GAIN_P   = 3'd2,
    REG_GAIN_I   = 3'd3,
    REG_GAIN_D   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
  } gains_t;

endpackage

[sv/dual_pid_pwm_duty.sv]
// Two-channel incremental PID regulator producing PWM duty and enable per channel.
// An accepted sample pair is held in the input register, and its result then in the output register.
// Throughput: one sample pair per cycle while the output is not stalled; the input register feeds
// both channel updates, whose state updates as the pair moves into the output register.
// Reset clears both channels' state and pipeline valids, zeroes the targets and
// loads the default gains.
`timescale 1ns / 1ps

module dual_pid_pwm_duty (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [dpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dpp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dpp_pkg::SAMPLE_BITS-1:0] sample_a,
  input  logic [dpp_pkg::SAMPLE_BITS-1:0] sample_b,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dpp_pkg::DUTY_W-1:0]      duty_a,
  output logic                            enable_a,
  output logic [dpp_pkg::DUTY_W-1:0]      duty_b,
  output logic                            enable_b
);
  import dpp_pkg::*;

  logic [TARGET_W-1:0]    target_a;
  logic [TARGET_W-1:0]    target_b;
  gains_t                 gains;

  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_sample_a;
  logic [SAMPLE_BITS-1:0] s1_sample_b;

  logic                   advance;
  logic                   step;
  logic [DUTY_W-1:0]      duty_a_next;
  logic [DUTY_W-1:0]      duty_b_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_a     <= '0;
      target_b     <= '0;
      gains.gain_p <= GAIN_P_RESET;
      gains.gain_i <= GAIN_I_RESET;
      gains.gain_d <= GAIN_D_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_A: target_a     <= cfg_data[TARGET_W-1:0];
        REG_TARGET_B: target_b     <= cfg_data[TARGET_W-1:0];
        REG_GAIN_P:   gains.gain_p <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:   gains.gain_i <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:   gains.gain_d <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The output register takes a new result whenever it is empty or being drained.
  assign advance  = !out_valid || !out_stall;
  assign step     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample_a <= sample_a;
      s1_sample_b <= sample_b;
    end
  end

  dpp_channel u_chan_a (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .sample (s1_sample_a),
    .target (target_a),
    .gains  (gains),
    .duty   (duty_a_next)
  );

  dpp_channel u_chan_b (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .sample (s1_sample_b),
    .target (target_b),
    .gains  (gains),
    .duty   (duty_b_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      duty_a   <= duty_a_next;
      enable_a <= (duty_a_next != '0);
      duty_b   <= duty_b_next;
      enable_b <= (duty_b_next != '0);
    end
  end

  a_duty_limit : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty_a <= DUTY_W'(OUTPUT_LIMIT)) && (duty_b <= DUTY_W'(OUTPUT_LIMIT)))
    else $error("duty above output limit");

  a_enable_match : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (enable_a == (duty_a != '0)) && (enable_b == (duty_b != '0)))
    else $error("enable does not follow duty");

  a_stall_only_when_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a full pipeline");

  a_step_fills_output : assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("channel update without a result");

endmodule

[sv/dpp_channel.sv]
// One PID channel: error sum, previous error and output accumulator with the update logic.
`timescale 1ns / 1ps

module dpp_channel (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [dpp_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [dpp_pkg::TARGET_W-1:0] target,
  input  dpp_pkg::gains_t              gains,
  output logic [dpp_pkg::DUTY_W-1:0]   duty
);
  import dpp_pkg::*;

  logic signed [SUM_W-1:0]    error_total;
  logic signed [ERR_W-1:0]    previous_error;
  logic        [DRIVE_W-1:0]  drive_accumulator;

  logic signed [ERR_W-1:0]    err;
  logic signed [SUM_W:0]      sum_wide;
  logic signed [SUM_W-1:0]    error_total_next;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [WIDE_W-1:0]   acc_wide;
  logic        [DRIVE_W-1:0]  drive_accumulator_next;

  assign err  = $signed({1'b0, sample}) - $signed({1'b0, target});
  assign diff = DIFF_W'(err) - DIFF_W'(previous_error);

  always_comb begin
    sum_wide = (SUM_W+1)'(error_total) + (SUM_W+1)'(err);
    if (sum_wide > (SUM_W+1)'(SUM_MAX)) begin
      error_total_next = SUM_MAX;
    end else if (sum_wide < (SUM_W+1)'(SUM_MIN)) begin
      error_total_next = SUM_MIN;
    end else begin
      error_total_next = sum_wide[SUM_W-1:0];
    end
  end

  assign prod_p = $signed({1'b0, gains.gain_p}) * err;
  assign prod_i = $signed({1'b0, gains.gain_i}) * error_total_next;
  assign prod_d = $signed({1'b0, gains.gain_d}) * diff;

  // The sum is wide enough that no term can wrap before the clamp.
  always_comb begin
    acc_wide = $signed({{(WIDE_W-DRIVE_W){1'b0}}, drive_accumulator})
             - WIDE_W'(prod_p) - WIDE_W'(prod_i) - WIDE_W'(prod_d);
    if (acc_wide < 0) begin
      drive_accumulator_next = '0;
    end else if (acc_wide > $signed({{(WIDE_W-DRIVE_W){1'b0}}, DRIVE_LIMIT})) begin
      drive_accumulator_next = DRIVE_LIMIT;
    end else begin
      drive_accumulator_next = acc_wide[DRIVE_W-1:0];
    end
  end

  assign duty = drive_accumulator_next[FRAC_BITS +: DUTY_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      error_total       <= '0;
      previous_error    <= '0;
      drive_accumulator <= '0;
    end else if (step) begin
      error_total       <= error_total_next;
      previous_error    <= err;
      drive_accumulator <= drive_accumulator_next;
    end
  end

endmodule

[test/dual_pid_pwm_duty_checker.sv]
// Scoreboard for the dual-channel PID duty block: predicts every duty pair and compares it.
`timescale 1ns / 1ps

module dual_pid_pwm_duty_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [dpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dpp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [dpp_pkg::SAMPLE_BITS-1:0] sample_a,
  input  logic [dpp_pkg::SAMPLE_BITS-1:0] sample_b,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [dpp_pkg::DUTY_W-1:0]      duty_a,
  input  logic                            enable_a,
  input  logic [dpp_pkg::DUTY_W-1:0]      duty_b,
  input  logic                            enable_b,
  output int                              mismatches,
  output int                              outstanding
);
  import dpp_pkg::*;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic              enable_a;
    logic [DUTY_W-1:0] duty_b;
    logic              enable_b;
  } duty_pair_t;

  logic [TARGET_W-1:0]     setpoint [2];
  gains_t                  gains;
  logic signed [SUM_W-1:0] err_sum  [2];
  logic signed [ERR_W-1:0] last_err [2];
  logic [DRIVE_W-1:0]      drive    [2];
  duty_pair_t              expected_duty [$];
  int                      fail_count = 0;

  assign mismatches = fail_count;

  initial outstanding = 0;

  // One incremental PID step for one channel; updates that channel's state.
  function automatic logic [DUTY_W-1:0] regulate(input int ch,
                                                 input logic [SAMPLE_BITS-1:0] sample);
    longint err;
    longint sum;
    longint acc;
    err = longint'(sample) - longint'(setpoint[ch]);
    sum = longint'(err_sum[ch]) + err;
    if (sum > longint'(SUM_MAX)) sum = longint'(SUM_MAX);
    if (sum < longint'(SUM_MIN)) sum = longint'(SUM_MIN);
    acc = longint'(drive[ch])
        - longint'(gains.gain_p) * err
        - longint'(gains.gain_i) * sum
        - longint'(gains.gain_d) * (err - longint'(last_err[ch]));
    if (acc > longint'(DRIVE_LIMIT)) acc = longint'(DRIVE_LIMIT);
    if (acc < 0) acc = 0;
    err_sum[ch]  = SUM_W'(sum);
    last_err[ch] = ERR_W'(err);
    drive[ch]    = DRIVE_W'(acc);
    return DUTY_W'(acc >>> FRAC_BITS);
  endfunction

  always @(posedge clk) begin : watch
    duty_pair_t got;
    duty_pair_t want;
    if (rst) begin
      setpoint[0] = '0;
      setpoint[1] = '0;
      gains       = '{GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET};
      for (int ch = 0; ch < 2; ch++) begin
        err_sum[ch]  = '0;
        last_err[ch] = '0;
        drive[ch]    = '0;
      end
      expected_duty.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TARGET_A: setpoint[0]  = cfg_data[TARGET_W-1:0];
          REG_TARGET_B: setpoint[1]  = cfg_data[TARGET_W-1:0];
          REG_GAIN_P:   gains.gain_p = cfg_data[GAIN_W-1:0];
          REG_GAIN_I:   gains.gain_i = cfg_data[GAIN_W-1:0];
          REG_GAIN_D:   gains.gain_d = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{duty_a, enable_a, duty_b, enable_b};
        if (expected_duty.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: duty transaction with none pending: a=%0d/%b b=%0d/%b",
                     $realtime, got.duty_a, got.enable_a, got.duty_b, got.enable_b);
          fail_count++;
        end else begin
          want = expected_duty.pop_front();
          if (got.duty_a !== want.duty_a || got.enable_a !== want.enable_a ||
              got.duty_b !== want.duty_b || got.enable_b !== want.enable_b) begin
            if (fail_count < 10)
              $display("%0t: duty mismatch: expected a=%0d/%b b=%0d/%b, got a=%0d/%b b=%0d/%b",
                       $realtime, want.duty_a, want.enable_a, want.duty_b, want.enable_b,
                       got.duty_a, got.enable_a, got.duty_b, got.enable_b);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want.duty_a   = regulate(0, sample_a);
        want.enable_a = (want.duty_a != '0);
        want.duty_b   = regulate(1, sample_b);
        want.enable_b = (want.duty_b != '0);
        expected_duty.push_back(want);
      end
    end
    outstanding <= expected_duty.size();
  end

endmodule

[test/dual_pid_pwm_duty_test.sv]
// Top of the dual-channel PID duty testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module dual_pid_pwm_duty_test;
  import dpp_pkg::*;

  localparam int NUM_REGS    = 5;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [GAIN_W-1:0]      GAIN_TOP   = '1;
  localparam int IDLE_LIMIT  = 2000;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] sample_a  = '0;
  logic [SAMPLE_BITS-1:0] sample_b  = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [DUTY_W-1:0]      duty_a;
  logic                   enable_a;
  logic [DUTY_W-1:0]      duty_b;
  logic                   enable_b;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  int stall_left  = 0;
  logic stall_on  = 1'b1;
  bit idle_on     = 1'b1;
  logic [SAMPLE_BITS-1:0] cur_target_a = '0;
  logic [SAMPLE_BITS-1:0] cur_target_b = '0;

  dual_pid_pwm_duty dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_a  (sample_a),
    .sample_b  (sample_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .duty_a    (duty_a),
    .enable_a  (enable_a),
    .duty_b    (duty_b),
    .enable_b  (enable_b)
  );

  dual_pid_pwm_duty_checker duty_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_a    (sample_a),
    .sample_b    (sample_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .duty_a      (duty_a),
    .enable_a    (enable_a),
    .duty_b      (duty_b),
    .enable_b    (enable_b),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short bursts, now and then a long one.
  function automatic int burst_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  always @(posedge clk) begin
    if (!stall_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left <= 1) begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= burst_len();
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("dual_pid_pwm_duty_test: FAIL");
        $finish;
      end
    end
  end

  task automatic send_samples(input logic [SAMPLE_BITS-1:0] a,
                              input logic [SAMPLE_BITS-1:0] b);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? burst_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_a <= a;
    sample_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every pending duty transaction has come out.
  task automatic quiet_down();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [SAMPLE_BITS-1:0] ta,
                              input logic [SAMPLE_BITS-1:0] tb,
                              input logic [GAIN_W-1:0] gp,
                              input logic [GAIN_W-1:0] gi,
                              input logic [GAIN_W-1:0] gd);
    quiet_down();
    // Targets carry junk in the upper data bits, which must be dropped.
    cfg_write <= 1'b1;
    cfg_index <= REG_TARGET_A;
    cfg_data  <= {(CFG_DATA_W-TARGET_W)'($urandom), ta};
    @(posedge clk);
    cfg_index <= REG_TARGET_B;
    cfg_data  <= {(CFG_DATA_W-TARGET_W)'($urandom), tb};
    @(posedge clk);
    cfg_index <= REG_GAIN_P;
    cfg_data  <= gp;
    @(posedge clk);
    cfg_index <= REG_GAIN_I;
    cfg_data  <= gi;
    @(posedge clk);
    cfg_index <= REG_GAIN_D;
    cfg_data  <= gd;
    @(posedge clk);
    // A write to an unused index must leave every register alone.
    cfg_index <= CFG_INDEX_W'(NUM_REGS + $urandom_range(0, 2));
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_target_a = ta;
    cur_target_b = tb;
  endtask

  // Mostly readings that hover around the setpoint, plus uniform noise and extremes.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(input logic [SAMPLE_BITS-1:0] target);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      v = int'(target) + int'($urandom_range(0, 40)) - 20;
      if (v < 0) v = 0;
      if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
      return SAMPLE_BITS'(v);
    end
    if (r < 85) return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return SAMPLE_MAX;
      2: return 10'h155;
      default: return 10'h2AA;
    endcase
  endfunction

  task automatic regulate_run(input int count);
    repeat (count) send_samples(pick_sample(cur_target_a), pick_sample(cur_target_b));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Settings out of reset.
    send_samples('0, '0);
    send_samples(SAMPLE_MAX, '0);
    send_samples('0, SAMPLE_MAX);
    send_samples(SAMPLE_MAX, SAMPLE_MAX);
    send_samples(10'h2AA, 10'h155);
    send_samples(10'h155, 10'h2AA);

    // Full gains and far setpoints drive the output to its upper clamp.
    program_regs(SAMPLE_MAX, SAMPLE_MAX, GAIN_TOP, GAIN_TOP, GAIN_TOP);
    repeat (3) send_samples('0, '0);
    send_samples(SAMPLE_MAX, SAMPLE_MAX);
    repeat (2) send_samples('0, SAMPLE_MAX);

    // Zero gains hold the output where it is.
    program_regs('0, SAMPLE_MAX, '0, '0, '0);
    repeat (2) send_samples(10'd512, 10'd512);

    program_regs(10'd512, 10'd512, GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);
    send_samples(10'd500, 10'd524);
    send_samples(10'd524, 10'd500);
    repeat (3) send_samples(10'd512, 10'd512);

    // Hold the errors near their extremes, one channel each way, then reverse.
    idle_on = 1'b0;
    program_regs('0, SAMPLE_MAX, GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);
    repeat (110)
      send_samples(SAMPLE_BITS'(SAMPLE_MAX - $urandom_range(0, 7)),
                   SAMPLE_BITS'($urandom_range(0, 7)));
    program_regs(SAMPLE_MAX, '0, GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);
    repeat (110)
      send_samples(SAMPLE_BITS'($urandom_range(0, 7)),
                   SAMPLE_BITS'(SAMPLE_MAX - $urandom_range(0, 7)));

    idle_on = 1'b1;
    program_regs(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                 SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                 GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);
    regulate_run(60);

    // A stretch with no gaps and no back-pressure.
    idle_on = 1'b0;
    stall_on <= 1'b0;
    program_regs(SAMPLE_MAX, '0, GAIN_TOP, GAIN_TOP, GAIN_TOP);
    regulate_run(60);

    idle_on = 1'b1;
    stall_on <= 1'b1;
    program_regs(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                 SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                 GAIN_W'($urandom_range(0, GAIN_TOP)),
                 GAIN_W'($urandom_range(0, GAIN_TOP)),
                 GAIN_W'($urandom_range(0, GAIN_TOP)));
    regulate_run(60);

    // Small gains give a slow loop whose duty settles across the whole range.
    program_regs(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                 SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                 GAIN_W'($urandom_range(0, 65535)),
                 GAIN_W'($urandom_range(0, 2047)),
                 GAIN_W'($urandom_range(0, 65535)));
    regulate_run(60);

    program_regs('0, SAMPLE_MAX, GAIN_W'($urandom_range(0, GAIN_TOP)), '0, GAIN_TOP);
    regulate_run(60);

    quiet_down();
    if (mismatches == 0)
      $display("dual_pid_pwm_duty_test: PASS");
    else
      $display("dual_pid_pwm_duty_test: FAIL");
    $finish;
  end

endmodule

[dual_pid_pwm_duty.f]
sv/dpp_pkg.sv
sv/dpp_channel.sv
sv/dual_pid_pwm_duty.sv
test/dual_pid_pwm_duty_checker.sv
test/dual_pid_pwm_duty_test.sv
